// ----- rtl/core/grsp_pkg.sv -----
// ----------------------------------------------------------------------------
// grsp_pkg
// Shared constants and codes of the greedy random shortest pick core.
// ----------------------------------------------------------------------------
package grsp_pkg;

	localparam int JOB_COUNT_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int JOB_W  = 4;
	localparam int DUR_W  = 16;
	localparam int RAND_W = 16;

	typedef enum logic [1:0] {
		ST_PICKED    = 2'd0,
		ST_NONE      = 2'd1,
		ST_LOAD_OK   = 2'd2,
		ST_LOAD_FULL = 2'd3
	} status_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PICK = 1'b1;

endpackage

// ----- rtl/core/greedy_random_shortest_pick_core.sv -----
// ----------------------------------------------------------------------------
// greedy_random_shortest_pick_core
// Per-job duration queues with a randomized shortest-head pick.
// ----------------------------------------------------------------------------
// A load goes from start through S_LOAD and S_FIN to the done strobe. A pick
// does one memory read per job to fetch every queue head, then, when more
// than one head is live, two bit-serial remainder passes on one shared unit,
// then a walk over the jobs that ranks one head per cycle. busy stays high for the
// whole item; each result is shown for exactly one cycle on done and the
// receiver cannot stall it.
module greedy_random_shortest_pick_core #(
	parameter int JOB_COUNT   = grsp_pkg::JOB_COUNT_DEF,
	parameter int QUEUE_DEPTH = grsp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [grsp_pkg::JOB_W-1:0]  job,
	input  logic [grsp_pkg::DUR_W-1:0]  duration,
	input  logic [grsp_pkg::RAND_W-1:0] rand_size,
	input  logic [grsp_pkg::RAND_W-1:0] rand_pick,
	output logic                       done,
	output logic [grsp_pkg::JOB_W-1:0]  picked_job,
	output logic [grsp_pkg::DUR_W-1:0]  picked_duration,
	output grsp_pkg::status_t          status,
	output logic                       all_empty
);

	localparam int JW    = $clog2(JOB_COUNT);
	localparam int NW    = $clog2(JOB_COUNT + 1);
	localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SW    = CW + 1;
	localparam int DEPTH = JOB_COUNT * QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int DUR_W = grsp_pkg::DUR_W;
	localparam int RW    = grsp_pkg::RAND_W;
	localparam int BW    = $clog2(RW);

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_SCAN, S_MOD_SIZE, S_MOD_PICK, S_SELECT, S_POP, S_FIN
	} state_t;

	state_t state_q;

	logic [DUR_W-1:0] mem [DEPTH];
	logic [DUR_W-1:0] rd_q;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic             wr_en;

	logic [HW-1:0]    head_q [JOB_COUNT];
	logic [CW-1:0]    cnt_q  [JOB_COUNT];
	logic [DUR_W-1:0] heads_q [JOB_COUNT];

	logic [grsp_pkg::JOB_W-1:0]  job_q;
	logic [DUR_W-1:0]           dur_q;
	logic [RW-1:0]              rpick_q;
	logic [RW-1:0]              rsize_q;

	logic [NW-1:0] sc_q;
	logic [NW-1:0] sc_m1;
	logic [JW-1:0] sc_idx;
	logic [JW-1:0] sel_q;
	logic [NW-1:0] want_q;

	logic [RW-1:0] dvd_q;
	logic [NW-1:0] dvs_q;
	logic [NW-1:0] rem_q;
	logic [BW-1:0] bit_q;
	logic [NW:0]   rem_ext;
	logic [NW-1:0] rem_nx;

	logic [JOB_COUNT-1:0] valid;
	logic [NW-1:0]        n_heads;
	logic [NW-1:0]        rank;
	logic [JW-1:0]        ld_idx;
	logic                 ld_bad;
	logic [SW-1:0]        slot_sum;
	logic [HW-1:0]        slot;

	logic                       done_q;
	logic [grsp_pkg::JOB_W-1:0]  pj_q;
	logic [DUR_W-1:0]           pd_q;
	grsp_pkg::status_t          st_q;
	logic                       ae_q;

	always_comb begin
		n_heads = '0;
		for (int j = 0; j < JOB_COUNT; j++) begin
			valid[j] = (cnt_q[j] != '0);
			n_heads  = n_heads + NW'(valid[j]);
		end
	end

	// rank of the head under the select pointer among all live heads
	always_comb begin
		rank = '0;
		for (int m = 0; m < JOB_COUNT; m++) begin
			if (valid[m] && (JW'(m) != sel_q)
					&& ({heads_q[m], JW'(m)} < {heads_q[sel_q], sel_q})) begin
				rank = rank + NW'(1);
			end
		end
	end

	assign rem_ext = {rem_q, dvd_q[RW-1]};
	assign rem_nx  = (rem_ext >= {1'b0, dvs_q}) ? NW'(rem_ext - {1'b0, dvs_q})
		: rem_ext[NW-1:0];

	assign sc_m1  = sc_q - NW'(1);
	assign sc_idx = (int'(sc_q) < JOB_COUNT) ? sc_q[JW-1:0] : '0;
	assign rd_addr = AW'(int'(sc_idx) * QUEUE_DEPTH + int'(head_q[sc_idx]));

	assign ld_bad   = (int'(job_q) >= JOB_COUNT);
	assign ld_idx   = ld_bad ? '0 : JW'(job_q);
	assign slot_sum = SW'(head_q[ld_idx]) + SW'(cnt_q[ld_idx]);
	assign slot     = (int'(slot_sum) >= QUEUE_DEPTH) ? HW'(int'(slot_sum) - QUEUE_DEPTH)
		: HW'(slot_sum);
	assign wr_addr  = AW'(int'(ld_idx) * QUEUE_DEPTH + int'(slot));
	assign wr_en    = (state_q == S_LOAD) && !ld_bad
		&& (int'(cnt_q[ld_idx]) < QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= dur_q;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			for (int j = 0; j < JOB_COUNT; j++) begin
				head_q[j] <= '0;
				cnt_q[j]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						job_q   <= job;
						dur_q   <= duration;
						rsize_q <= rand_size;
						rpick_q <= rand_pick;
						sc_q    <= '0;
						state_q <= (op == grsp_pkg::OP_LOAD) ? S_LOAD : S_SCAN;
					end
				end
				S_LOAD: begin
					pj_q <= '0;
					pd_q <= '0;
					if (wr_en) begin
						cnt_q[ld_idx] <= cnt_q[ld_idx] + CW'(1);
						st_q          <= grsp_pkg::ST_LOAD_OK;
					end else begin
						st_q <= grsp_pkg::ST_LOAD_FULL;
					end
					state_q <= S_FIN;
				end
				S_SCAN: begin
					// read data lags the issued address by one job
					if (sc_q != '0) begin
						heads_q[sc_m1[JW-1:0]] <= rd_q;
					end
					sc_q <= sc_q + NW'(1);
					if (int'(sc_q) == JOB_COUNT) begin
						rem_q <= '0;
						bit_q <= '0;
						dvd_q <= rsize_q;
						dvs_q <= n_heads - NW'(1);
						want_q <= '0;
						sel_q  <= '0;
						if (n_heads == '0) begin
							pj_q    <= '0;
							pd_q    <= '0;
							st_q    <= grsp_pkg::ST_NONE;
							state_q <= S_FIN;
						end else if (n_heads == NW'(1)) begin
							state_q <= S_SELECT;
						end else begin
							state_q <= S_MOD_SIZE;
						end
					end
				end
				S_MOD_SIZE: begin
					rem_q <= rem_nx;
					dvd_q <= dvd_q << 1;
					bit_q <= bit_q + BW'(1);
					if (bit_q == BW'(RW - 1)) begin
						rem_q   <= '0;
						dvd_q   <= rpick_q;
						dvs_q   <= rem_nx + NW'(2);
						state_q <= S_MOD_PICK;
					end
				end
				S_MOD_PICK: begin
					rem_q <= rem_nx;
					dvd_q <= dvd_q << 1;
					bit_q <= bit_q + BW'(1);
					if (bit_q == BW'(RW - 1)) begin
						want_q  <= rem_nx;
						state_q <= S_SELECT;
					end
				end
				S_SELECT: begin
					if (valid[sel_q] && (rank == want_q)) begin
						state_q <= S_POP;
					end else begin
						sel_q <= sel_q + JW'(1);
					end
				end
				S_POP: begin
					pj_q <= grsp_pkg::JOB_W'(sel_q);
					pd_q <= heads_q[sel_q];
					st_q <= grsp_pkg::ST_PICKED;
					head_q[sel_q] <= (int'(head_q[sel_q]) == QUEUE_DEPTH - 1) ? '0
						: head_q[sel_q] + HW'(1);
					cnt_q[sel_q] <= cnt_q[sel_q] - CW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					ae_q    <= ~|valid;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign picked_job      = pj_q;
	assign picked_duration = pd_q;
	assign status          = st_q;
	assign all_empty       = ae_q;

endmodule

// ----- rtl/core/grsp_checker.sv -----
// ----------------------------------------------------------------------------
// grsp_checker
// Port-level checks of the greedy random shortest pick core.
// ----------------------------------------------------------------------------
module grsp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [grsp_pkg::JOB_W-1:0]  picked_job,
	input logic [grsp_pkg::DUR_W-1:0]  picked_duration,
	input grsp_pkg::status_t          status,
	input logic                       all_empty
);

	// an accepted beat keeps the core busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat without busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_no_pick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != grsp_pkg::ST_PICKED) |-> (picked_job == '0)
			&& (picked_duration == '0)) else $error("nonzero payload without pick");

	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == grsp_pkg::ST_LOAD_OK) |-> !all_empty)
		else $error("empty after accepted load");

endmodule

bind greedy_random_shortest_pick_core grsp_checker u_grsp_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.picked_job(picked_job), .picked_duration(picked_duration),
	.status(status), .all_empty(all_empty)
);

// ----- sim/greedy_random_shortest_pick_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_random_shortest_pick_core_tb
// Drives loads and picks into the core and checks every done beat against a
// cycle-free model of the per-job queues and the randomized shortest pick.
// ----------------------------------------------------------------------------
module greedy_random_shortest_pick_core_tb;

	localparam int NJOB      = grsp_pkg::JOB_COUNT_DEF;
	localparam int QDEPTH    = grsp_pkg::QUEUE_DEPTH_DEF;
	localparam int CYC_LIMIT = 2000000;

	typedef struct packed {
		logic [grsp_pkg::JOB_W-1:0] pjob;
		logic [grsp_pkg::DUR_W-1:0] pdur;
		grsp_pkg::status_t          st;
		logic                       empty;
	} pick_result_t;

	typedef struct packed {
		logic                        op;
		logic [grsp_pkg::JOB_W-1:0]  job;
		logic [grsp_pkg::DUR_W-1:0]  dur;
		logic [grsp_pkg::RAND_W-1:0] rsize;
		logic [grsp_pkg::RAND_W-1:0] rpick;
		logic                        typed;
		pick_result_t                res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic op = grsp_pkg::OP_LOAD;
	logic [grsp_pkg::JOB_W-1:0] job = '0;
	logic [grsp_pkg::DUR_W-1:0] duration = '0;
	logic [grsp_pkg::RAND_W-1:0] rand_size = '0;
	logic [grsp_pkg::RAND_W-1:0] rand_pick = '0;
	logic busy, done, all_empty;
	logic [grsp_pkg::JOB_W-1:0] picked_job;
	logic [grsp_pkg::DUR_W-1:0] picked_duration;
	grsp_pkg::status_t status;

	greedy_random_shortest_pick_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.job(job), .duration(duration), .rand_size(rand_size),
		.rand_pick(rand_pick), .done(done), .picked_job(picked_job),
		.picked_duration(picked_duration), .status(status),
		.all_empty(all_empty)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// queue model
	logic [grsp_pkg::DUR_W-1:0] dur_mem [NJOB][QDEPTH];
	int unsigned      q_head [NJOB];
	int unsigned      q_count [NJOB];

	pick_result_t pending_results[$];
	int           errors = 0;
	int unsigned  accepted = 0;
	int unsigned  cycles = 0;
	logic         row_typed = 1'b0;
	pick_result_t row_res;
	logic         idle_on = 1'b1;

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic pick_result_t model_step(input logic o, input logic [3:0] j,
			input logic [15:0] d, input logic [15:0] rs, input logic [15:0] rp);
		pick_result_t r;
		int unsigned cand[NJOB];
		int unsigned n, k, want, rank, sel;
		logic [grsp_pkg::DUR_W-1:0] di, dm;
		r = '{pjob: '0, pdur: '0, st: grsp_pkg::ST_PICKED, empty: 1'b0};
		n = 0;
		sel = 0;
		if (o == grsp_pkg::OP_LOAD) begin
			if (q_count[j] >= QDEPTH) begin
				r.st = grsp_pkg::ST_LOAD_FULL;
			end else begin
				dur_mem[j][(q_head[j] + q_count[j]) % QDEPTH] = d;
				q_count[j]++;
				r.st = grsp_pkg::ST_LOAD_OK;
			end
		end else begin
			for (int i = 0; i < NJOB; i++)
				if (q_count[i] != 0) begin
					cand[n] = i;
					n++;
				end
			if (n == 0) begin
				r.st = grsp_pkg::ST_NONE;
			end else begin
				if (n == 1) begin
					sel = cand[0];
				end else begin
					k = 2 + rs % (n - 1);
					want = rp % k;
					for (int i = 0; i < n; i++) begin
						rank = 0;
						di = dur_mem[cand[i]][q_head[cand[i]]];
						for (int m = 0; m < n; m++) begin
							dm = dur_mem[cand[m]][q_head[cand[m]]];
							// ties go to the lower job
							if (m != i && (dm < di || (dm == di && cand[m] < cand[i])))
								rank++;
						end
						if (rank == want) begin
							sel = cand[i];
							break;
						end
					end
				end
				r.pjob = grsp_pkg::JOB_W'(sel);
				r.pdur = dur_mem[sel][q_head[sel]];
				q_head[sel] = (q_head[sel] + 1) % QDEPTH;
				q_count[sel]--;
				r.st = grsp_pkg::ST_PICKED;
			end
		end
		r.empty = 1'b1;
		for (int i = 0; i < NJOB; i++)
			if (q_count[i] != 0)
				r.empty = 1'b0;
		return r;
	endfunction

	// accept and check at the rising edge
	always @(posedge clk) begin
		pick_result_t p, e;
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("greedy_random_shortest_pick_core verification failed");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report("done beat with nothing expected");
				end else begin
					e = pending_results.pop_front();
					if (picked_job !== e.pjob)
						report($sformatf("picked_job %0d exp %0d", picked_job, e.pjob));
					if (picked_duration !== e.pdur)
						report($sformatf("picked_duration %0d exp %0d",
							picked_duration, e.pdur));
					if (status !== e.st)
						report($sformatf("status %0d exp %0d", status, e.st));
					if (all_empty !== e.empty)
						report($sformatf("all_empty %0b exp %0b", all_empty, e.empty));
				end
			end
			if (start && !busy) begin
				p = model_step(op, job, duration, rand_size, rand_pick);
				pending_results = {pending_results, (row_typed ? row_res : p)};
				accepted++;
			end
		end
	end

	task automatic send(input logic o, input logic [3:0] j, input logic [15:0] d,
			input logic [15:0] rs, input logic [15:0] rp);
		int unsigned seen;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		op = o;
		job = j;
		duration = d;
		rand_size = rs;
		rand_pick = rp;
		start = 1'b1;
		seen = accepted;
		while (accepted == seen)
			@(negedge clk);
		row_typed = 1'b0;
	endtask

	task automatic send_random(input int unsigned load_pct, input int unsigned dur_max);
		logic [15:0] d;
		d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, dur_max));
		send(($urandom_range(0, 99) < load_pct) ? grsp_pkg::OP_LOAD : grsp_pkg::OP_PICK,
			4'($urandom), d, 16'($urandom), 16'($urandom));
	endtask

	stim_row_t rows[] = '{
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			'{4'd0, 16'd0, grsp_pkg::ST_NONE, 1'b1}},
		'{grsp_pkg::OP_LOAD, 4'd0, 16'h0000, 16'hffff, 16'hffff, 1'b1,
			'{4'd0, 16'd0, grsp_pkg::ST_LOAD_OK, 1'b0}},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'hffff, 16'hffff, 1'b1,
			'{4'd0, 16'd0, grsp_pkg::ST_PICKED, 1'b1}},
		'{grsp_pkg::OP_LOAD, 4'd15, 16'hffff, 16'h0000, 16'h0000, 1'b1,
			'{4'd0, 16'd0, grsp_pkg::ST_LOAD_OK, 1'b0}},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			'{4'd15, 16'hffff, grsp_pkg::ST_PICKED, 1'b1}},
		// equal heads, lower job ranks first
		'{grsp_pkg::OP_LOAD, 4'd9, 16'd100, 16'h0000, 16'h0000, 1'b0, '0},
		'{grsp_pkg::OP_LOAD, 4'd4, 16'd100, 16'h0000, 16'h0000, 1'b0, '0},
		'{grsp_pkg::OP_LOAD, 4'd4, 16'd7, 16'h0000, 16'h0000, 1'b0, '0},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'h0000, 16'h0001, 1'b0, '0},
		'{grsp_pkg::OP_LOAD, 4'd1, 16'h5555, 16'h0000, 16'h0000, 1'b0, '0},
		'{grsp_pkg::OP_LOAD, 4'd2, 16'haaaa, 16'h0000, 16'h0000, 1'b0, '0},
		'{grsp_pkg::OP_LOAD, 4'd3, 16'h0001, 16'h0000, 16'h0000, 1'b0, '0},
		'{grsp_pkg::OP_LOAD, 4'd14, 16'h8000, 16'h0000, 16'h0000, 1'b0, '0},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'hffff, 16'hffff, 1'b0, '0},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'h5555, 16'haaaa, 1'b0, '0},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'haaaa, 16'h5555, 1'b0, '0},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'h0003, 16'h0002, 1'b0, '0},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
		'{grsp_pkg::OP_PICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1,
			'{4'd0, 16'd0, grsp_pkg::ST_NONE, 1'b1}}
	};

	initial begin
		int unsigned wait_cyc;
		int unsigned fj;
		for (int i = 0; i < NJOB; i++) begin
			q_head[i] = 0;
			q_count[i] = 0;
			for (int s = 0; s < QDEPTH; s++)
				dur_mem[i][s] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[r]) begin
			row_typed = rows[r].typed;
			row_res = rows[r].res;
			send(rows[r].op, rows[r].job, rows[r].dur, rows[r].rsize, rows[r].rpick);
		end

		// full-queue beats, with a full drain so the head pointer wraps
		for (int rep = 0; rep < 3; rep++) begin
			fj = $urandom_range(0, NJOB - 1);
			for (int i = 0; i < QDEPTH + 2; i++)
				send(grsp_pkg::OP_LOAD, 4'(fj), 16'($urandom), 16'($urandom),
					16'($urandom));
			for (int i = 0; i < QDEPTH + 1; i++)
				send(grsp_pkg::OP_PICK, 4'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
		end

		for (int blk = 0; blk < 24; blk++) begin
			if (blk == 20)
				idle_on = 1'b0;
			if (blk == 10) begin
				// hold off until every expected beat has come back
				start = 1'b0;
				while (pending_results.size() != 0)
					@(negedge clk);
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			// fill phase then drain phase, small durations force ties
			for (int i = 0; i < 20; i++)
				send_random(80, (blk % 2) ? 3 : 65535);
			for (int i = 0; i < 20; i++)
				send_random(25, 65535);
		end

		start = 1'b0;
		wait_cyc = 0;
		while (pending_results.size() != 0 && wait_cyc < 10000) begin
			@(negedge clk);
			wait_cyc++;
		end
		repeat (80) @(negedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("greedy_random_shortest_pick_core verification clean");
		end else begin
			$display("greedy_random_shortest_pick_core verification failed");
		end
		$finish;
	end

endmodule
